// ----- rtl/hdd_pkg.sv -----
// Shared types, constants and code-tree tables for the prefix-code difference decoder.
`timescale 1ns / 1ps

package hdd_pkg;

    // Default width of the extra-bit field and the fixed field widths.
    localparam int DIFF_BITS_DEFAULT = 14;
    localparam int DIFF_W            = 15;
    localparam int LEN_W             = 4;
    localparam int NODE_W            = 5;
    localparam int TREE_NODES        = 32;
    localparam int NUM_SLOTS         = 2;
    localparam int SEL_W             = 2;

    // Code-tree selector values.
    localparam logic [SEL_W-1:0] TBL_LOSSY12   = 2'd0;
    localparam logic [SEL_W-1:0] TBL_LOSSY14   = 2'd1;
    localparam logic [SEL_W-1:0] TBL_LOSSLESS  = 2'd2;

    // One tree entry: an internal node sends bit 1 to val and bit 0 to the next node.
    // A leaf holds its length symbol in val.
    typedef struct packed {
        logic              leaf;
        logic [NODE_W-1:0] val;
    } tree_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } hdd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_empty;
    } hdd_status_t;

    // Tree tables, entries coded as {leaf, val}.
    localparam logic [NODE_W:0] TREE_LOSSY12 [TREE_NODES] = '{
        6'd6,  6'd3,  6'd37, 6'd5,  6'd36, 6'd35, 6'd10, 6'd9,  6'd38, 6'd34,
        6'd12, 6'd39, 6'd14, 6'd33, 6'd16, 6'd32, 6'd18, 6'd40, 6'd20, 6'd41,
        6'd22, 6'd43, 6'd24, 6'd42, 6'd26, 6'd44, 6'd32, 6'd32, 6'd32, 6'd32,
        6'd32, 6'd32
    };

    localparam logic [NODE_W:0] TREE_LOSSY14 [TREE_NODES] = '{
        6'd6,  6'd3,  6'd37, 6'd5,  6'd38, 6'd36, 6'd10, 6'd9,  6'd39, 6'd40,
        6'd14, 6'd13, 6'd35, 6'd41, 6'd18, 6'd17, 6'd34, 6'd33, 6'd22, 6'd21,
        6'd32, 6'd42, 6'd24, 6'd43, 6'd26, 6'd44, 6'd28, 6'd45, 6'd46, 6'd32,
        6'd32, 6'd32
    };

    localparam logic [NODE_W:0] TREE_LOSSLESS [TREE_NODES] = '{
        6'd6,  6'd3,  6'd39, 6'd5,  6'd38, 6'd40, 6'd10, 6'd9,  6'd37, 6'd41,
        6'd14, 6'd13, 6'd36, 6'd42, 6'd18, 6'd17, 6'd35, 6'd43, 6'd22, 6'd21,
        6'd44, 6'd34, 6'd24, 6'd32, 6'd26, 6'd33, 6'd28, 6'd45, 6'd46, 6'd32,
        6'd32, 6'd32
    };

    // Look up one node of the selected tree; the unused selector maps to the lossless tree.
    function automatic tree_entry_t tree_lookup(input logic [SEL_W-1:0] sel,
                                                input logic [NODE_W-1:0] node);
        tree_entry_t entry;
        case (sel)
            TBL_LOSSY12: entry = tree_entry_t'(TREE_LOSSY12[node]);
            TBL_LOSSY14: entry = tree_entry_t'(TREE_LOSSY14[node]);
            default:     entry = tree_entry_t'(TREE_LOSSLESS[node]);
        endcase
        return entry;
    endfunction

endpackage

// ----- rtl/hdd_in_if.sv -----
// Input channel interface: one compressed byte and its restart flag per transfer.
`timescale 1ns / 1ps

interface hdd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       restart;

    modport source (output valid, output stream_byte, output restart, input ready);
    modport sink   (input valid, input stream_byte, input restart, output ready);
endinterface

// ----- rtl/hdd_out_if.sv -----
// Output channel interface: one decoded difference and its end-of-byte mark per transfer.
`timescale 1ns / 1ps

interface hdd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [hdd_pkg::DIFF_W-1:0] difference;
    logic                              last_of_byte;

    modport source (output valid, output difference, output last_of_byte, input ready);
    modport sink   (input valid, input difference, input last_of_byte, output ready);
endinterface

// ----- rtl/hdd_controller.sv -----
// Sequencer that accepts a byte, steps through its eight bits and commits its results.
`timescale 1ns / 1ps

module hdd_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hdd_pkg::hdd_status_t status,
    output hdd_pkg::hdd_cmd_t    cmd
);
    import hdd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_COMMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;

    // Next state and bit counter.
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next   = ST_RUN;
                    bit_cnt_next = 3'd0;
                end
            end
            ST_RUN:
            begin
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands are decoded from the current state.
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.step   = (state_reg == ST_RUN);
        cmd.commit = (state_reg == ST_COMMIT) && status.out_empty;
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= 3'd0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

endmodule

// ----- rtl/hdd_datapath.sv -----
// Bit-serial tree walk, extra-bit gathering, sign extension and result buffering.
`timescale 1ns / 1ps

module hdd_datapath #(
    parameter int DIFF_BITS = hdd_pkg::DIFF_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hdd_pkg::hdd_cmd_t                 cmd,
    output hdd_pkg::hdd_status_t              status,
    input  logic                              cfg_wr_en,
    input  logic [hdd_pkg::SEL_W-1:0]         cfg_wr_data,
    input  logic [7:0]                        stream_byte,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hdd_pkg::DIFF_W-1:0] difference,
    output logic                              last_of_byte
);
    import hdd_pkg::*;

    localparam int EXT_W = (DIFF_BITS + 1 > DIFF_W) ? DIFF_BITS + 1 : DIFF_W;
    localparam int IDX_W = $clog2(DIFF_BITS);

    // Configuration and bit-walk state.
    logic [SEL_W-1:0]     sel_reg;
    logic [7:0]           byte_reg, byte_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic                 extra_reg, extra_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [DIFF_BITS-1:0] bits_reg, bits_next;

    // Per-byte result slots and the output buffer.
    logic [DIFF_W-1:0] slot_val_reg [NUM_SLOTS];
    logic [1:0]        slot_cnt_reg, slot_cnt_next;
    logic [DIFF_W-1:0] out_val_reg [NUM_SLOTS];
    logic              out_last_reg [NUM_SLOTS];
    logic [1:0]        out_cnt_reg, out_cnt_next;

    logic              cur_bit;
    logic              emit;
    logic [DIFF_W-1:0] emit_val;
    tree_entry_t       cur_entry, start_entry, child_entry;
    logic [NODE_W-1:0] start_node, child;
    logic [LEN_W-1:0]  leaf_len;
    logic [EXT_W-1:0]  ext_v, ext_mask, ext_diff;
    logic [IDX_W-1:0]  top_idx;
    logic              pop;

    assign cur_bit = byte_reg[7];

    // Sign extension of the gathered extra bits, used when the last one arrives.
    always_comb
    begin
        bits_next = {bits_reg[DIFF_BITS-2:0], cur_bit};
        ext_v     = EXT_W'(bits_next);
        ext_mask  = (EXT_W'(1) << len_reg) - EXT_W'(1);
        top_idx   = IDX_W'(len_reg - LEN_W'(1));
        ext_diff  = bits_next[top_idx] ? ext_v : (ext_v - ext_mask);
    end

    // Tree step: restart from the root if the held node is a leaf of this tree.
    always_comb
    begin
        cur_entry   = tree_lookup(sel_reg, node_reg);
        start_node  = cur_entry.leaf ? '0 : node_reg;
        start_entry = tree_lookup(sel_reg, start_node);
        child       = cur_bit ? start_entry.val : start_node + NODE_W'(1);
        child_entry = tree_lookup(sel_reg, child);
        leaf_len    = (int'(child_entry.val[LEN_W-1:0]) > DIFF_BITS) ?
                      LEN_W'(DIFF_BITS) : child_entry.val[LEN_W-1:0];
    end

    // Next value of the bit-walk state for one step.
    always_comb
    begin
        byte_next  = byte_reg;
        node_next  = node_reg;
        extra_next = extra_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        emit       = 1'b0;
        emit_val   = '0;
        if (cmd.load)
        begin
            byte_next = stream_byte;
            if (restart)
            begin
                node_next  = '0;
                extra_next = 1'b0;
                len_next   = '0;
                rem_next   = '0;
            end
        end
        else if (cmd.step)
        begin
            byte_next = {byte_reg[6:0], 1'b0};
            if (extra_reg)
            begin
                rem_next = rem_reg - LEN_W'(1);
                if (rem_reg == LEN_W'(1))
                begin
                    emit       = 1'b1;
                    emit_val   = ext_diff[DIFF_W-1:0];
                    node_next  = '0;
                    extra_next = 1'b0;
                    len_next   = '0;
                end
            end
            else if (child_entry.leaf)
            begin
                node_next = '0;
                if (leaf_len == '0)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    extra_next = 1'b1;
                    len_next   = leaf_len;
                    rem_next   = leaf_len;
                end
            end
            else
            begin
                node_next = child;
            end
        end
    end

    // Bit-walk registers and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= TBL_LOSSY12;
            node_reg  <= '0;
            extra_reg <= 1'b0;
            len_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sel_reg <= cfg_wr_data;
            end
            node_reg  <= node_next;
            extra_reg <= extra_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
        end
    end

    // Byte shifter and extra-bit shifter; a new code clears the extra bits.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if ((cmd.load && restart) || (cmd.step && !extra_reg))
        begin
            bits_reg <= '0;
        end
        else if (cmd.step)
        begin
            bits_reg <= bits_next;
        end
    end

    // Result slots: up to two differences per byte, later ones are dropped.
    always_comb
    begin
        slot_cnt_next = slot_cnt_reg;
        if (cmd.load)
        begin
            slot_cnt_next = 2'd0;
        end
        else if (emit && (slot_cnt_reg < 2'(NUM_SLOTS)))
        begin
            slot_cnt_next = slot_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && (slot_cnt_reg < 2'(NUM_SLOTS)))
        begin
            slot_val_reg[slot_cnt_reg[0]] <= emit_val;
        end
    end

    // Output buffer: filled from the slots at commit, drained one transfer at a time.
    assign pop = out_valid && out_ready;

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (cmd.commit)
        begin
            out_cnt_next = slot_cnt_reg;
        end
        else if (pop)
        begin
            out_cnt_next = out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg <= 2'd0;
            out_cnt_reg  <= 2'd0;
        end
        else
        begin
            slot_cnt_reg <= slot_cnt_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_val_reg[0]  <= slot_val_reg[0];
            out_val_reg[1]  <= slot_val_reg[1];
            out_last_reg[0] <= (slot_cnt_reg == 2'd1);
            out_last_reg[1] <= 1'b1;
        end
        else if (pop)
        begin
            out_val_reg[0]  <= out_val_reg[1];
            out_last_reg[0] <= out_last_reg[1];
        end
    end

    assign out_valid        = (out_cnt_reg != 2'd0);
    assign difference       = out_val_reg[0];
    assign last_of_byte     = out_last_reg[0];
    assign status.out_empty = (out_cnt_reg == 2'd0);

endmodule

// ----- rtl/huffman_difference_decoder_top.sv -----
// Top level of the prefix-code difference decoder: channels, register port and sub-blocks.
`timescale 1ns / 1ps

// The decoder takes one compressed byte per input transfer and uses its bits most
// significant first, one bit per clock, walking the code tree chosen by the table
// select register (0 lossy 12-bit, 1 lossy 14-bit, 2 or 3 lossless 14-bit) and then
// gathering the extra bits of each code, which are sign-extended into a difference.
// Code and extra-bit state carries over between bytes unless restart is set. Each byte
// is first taken, then goes through eight bit steps of the serial tree walk, and then has
// its zero, one or two differences moved into the output buffer; that move waits until
// the previous byte's differences have all been transferred, so a slow sink adds its
// stall time. The last difference kept for a byte carries last_of_byte.
// Write the table select register only while the decoder is idle.
module huffman_difference_decoder_top #(
    parameter int DIFF_BITS = hdd_pkg::DIFF_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [hdd_pkg::SEL_W-1:0] cfg_wr_data,
    hdd_in_if.sink                    in_stream,
    hdd_out_if.source                 out_diff
);
    import hdd_pkg::*;

    hdd_cmd_t    cmd;
    hdd_status_t status;

    // Sequencer.
    hdd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_stream.valid),
        .in_ready (in_stream.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Decoding datapath.
    hdd_datapath #(
        .DIFF_BITS (DIFF_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .stream_byte  (in_stream.stream_byte),
        .restart      (in_stream.restart),
        .out_valid    (out_diff.valid),
        .out_ready    (out_diff.ready),
        .difference   (out_diff.difference),
        .last_of_byte (out_diff.last_of_byte)
    );

endmodule
